// File: hdl/srpr_pkg.sv
package srpr_pkg;

   localparam int RATE_BITS = 18;
   localparam int FRAC_BITS = 24;
   localparam int PITCH_BITS = 32;
   localparam int QUOT_BITS = 32;
   localparam int NUM_CELLS = RATE_BITS + QUOT_BITS;
   localparam int CNT_BITS = 6;
   localparam int SH_BITS = 7;

   localparam logic [PITCH_BITS-1:0] WIN1_LO = PITCH_BITS'((64'h00428f5c << FRAC_BITS) >> 24);
   localparam logic [PITCH_BITS-1:0] WIN1_HI = PITCH_BITS'((64'h01b851ec << FRAC_BITS) >> 24);
   localparam logic [PITCH_BITS-1:0] WIN2_A  = PITCH_BITS'((64'h01d66666 << FRAC_BITS) >> 24);
   localparam logic [PITCH_BITS-1:0] WIN2_B  = PITCH_BITS'((64'h01d66667 << FRAC_BITS) >> 24);
   localparam logic [PITCH_BITS-1:0] WIN3    = PITCH_BITS'((64'h02000000 << FRAC_BITS) >> 24);
   localparam logic [PITCH_BITS-1:0] WIN_MAX = PITCH_BITS'((64'h08000000 << FRAC_BITS) >> 24);

   localparam logic [1:0] SEL_GENERAL = 2'd0;
   localparam logic [1:0] SEL_WIDE    = 2'd1;
   localparam logic [1:0] SEL_1P84    = 2'd2;
   localparam logic [1:0] SEL_TWO     = 2'd3;

   // One item as it travels down the cell row.
   typedef struct packed {
      logic                  valid;
      logic                  phase2;
      logic [RATE_BITS-1:0]  tgt;
      logic [RATE_BITS-1:0]  rem;
      logic [RATE_BITS-1:0]  num;
      logic [RATE_BITS-1:0]  quo;
      logic [QUOT_BITS-1:0]  dvd;
      logic [QUOT_BITS-1:0]  fq;
      logic [RATE_BITS-1:0]  tdiv;
      logic [RATE_BITS-1:0]  frem;
      logic                  fzero;
      logic [SH_BITS-1:0]    lz;
   } cell_type;

   // The rounded-up reciprocal of 100 in 2^32 units is exact for inputs below 2^24.
   function automatic logic [RATE_BITS-1:0] div100(input logic [RATE_BITS-1:0] x);
      logic [RATE_BITS+26-1:0] p;
      begin
         p = (RATE_BITS+26)'(x) * (RATE_BITS+26)'(26'd42949673);
         return RATE_BITS'(p >> 32);
      end
   endfunction

endpackage

// File: hdl/srpr_cell.sv
module srpr_cell
   import srpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_BITS-1:0] idx,
   input  cell_type          d_in,
   output cell_type          d_out
);
   cell_type d_ff, d_in_w;
   logic [RATE_BITS:0] trial;
   logic [RATE_BITS:0] ftrial;

   always_comb begin
      d_in_w = d_in;
      trial  = '0;
      ftrial = '0;
      if (32'(idx) < RATE_BITS) begin
         // Restoring step of source / target.
         trial = {d_in.rem, d_in.num[RATE_BITS-1]};
         d_in_w.num = {d_in.num[RATE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, d_in.tgt}) begin
            d_in_w.rem = RATE_BITS'(trial - {1'b0, d_in.tgt});
            d_in_w.quo = {d_in.quo[RATE_BITS-2:0], 1'b1};
         end else begin
            d_in_w.rem = RATE_BITS'(trial);
            d_in_w.quo = {d_in.quo[RATE_BITS-2:0], 1'b0};
         end
      end else begin
         // Restoring step of the normalized remainder / scaled target.
         ftrial = {d_in.frem, d_in.dvd[QUOT_BITS-1]};
         d_in_w.dvd = {d_in.dvd[QUOT_BITS-2:0], 1'b0};
         if (ftrial >= {1'b0, d_in.tdiv}) begin
            d_in_w.frem = RATE_BITS'(ftrial - {1'b0, d_in.tdiv});
            d_in_w.fq   = {d_in.fq[QUOT_BITS-2:0], 1'b1};
         end else begin
            d_in_w.frem = RATE_BITS'(ftrial);
            d_in_w.fq   = {d_in.fq[QUOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_ff.valid <= 1'b0;
      else d_ff.valid <= d_in.valid;
      {d_ff.phase2, d_ff.tgt, d_ff.rem, d_ff.num, d_ff.quo, d_ff.dvd, d_ff.fq,
       d_ff.tdiv, d_ff.frem, d_ff.fzero, d_ff.lz} <=
      {d_in_w.phase2, d_in_w.tgt, d_in_w.rem, d_in_w.num, d_in_w.quo, d_in_w.dvd,
       d_in_w.fq, d_in_w.tdiv, d_in_w.frem, d_in_w.fzero, d_in_w.lz};
   end

   assign d_out = d_ff;
endmodule

// File: hdl/srpr_norm.sv
module srpr_norm
   import srpr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type d_in,
   output cell_type d_out
);
   // Sits between the two divider halves: divides remainder and target by 100 and normalizes.
   cell_type d_ff, d_in_w;
   logic [RATE_BITS-1:0] r, t;
   logic [SH_BITS-1:0] lz;

   always_comb begin
      d_in_w = d_in;
      r  = div100(d_in.rem);
      t  = div100(d_in.tgt);
      lz = SH_BITS'(QUOT_BITS - 1);
      for (int i = 0; i < RATE_BITS; i++)
         if (r[i]) lz = SH_BITS'(QUOT_BITS - 1 - i);
      d_in_w.lz    = lz;
      d_in_w.tdiv  = t;
      d_in_w.frem  = '0;
      d_in_w.fq    = '0;
      d_in_w.fzero = (r == '0) || (t == '0) || (d_in.tgt == '0);
      d_in_w.dvd   = QUOT_BITS'({{(QUOT_BITS-RATE_BITS){1'b0}}, r} << lz);
      d_in_w.phase2 = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) d_ff.valid <= 1'b0;
      else d_ff.valid <= d_in.valid;
      {d_ff.phase2, d_ff.tgt, d_ff.rem, d_ff.num, d_ff.quo, d_ff.dvd, d_ff.fq,
       d_ff.tdiv, d_ff.frem, d_ff.fzero, d_ff.lz} <=
      {d_in_w.phase2, d_in_w.tgt, d_in_w.rem, d_in_w.num, d_in_w.quo, d_in_w.dvd,
       d_in_w.fq, d_in_w.tdiv, d_in_w.frem, d_in_w.fzero, d_in_w.lz};
   end

   assign d_out = d_ff;
endmodule

// File: hdl/sample_rate_pitch_ratio.sv
// Pitch ratio unit: req_source_rate / req_target_rate as unsigned 8.24 with a table
// choice. A new item is taken in every cycle (busy stays low), and its result appears
// on the rsp_ ports with rsp_valid high once it has passed 18 cells of the integer
// divider, one scaling and normalizing stage, 32 cells of the fraction divider and one
// output stage in turn. The receiver cannot stall, so results must be taken
// in the cycle they are shown.
module sample_rate_pitch_ratio
   import srpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [RATE_BITS-1:0]  req_source_rate,
   input  logic [RATE_BITS-1:0]  req_target_rate,
   output logic                  rsp_valid,
   output logic [PITCH_BITS-1:0] rsp_pitch,
   output logic [1:0]            rsp_table_select,
   output logic                  rsp_table_valid
);
   cell_type chain [0:NUM_CELLS+1];
   cell_type head;
   logic [PITCH_BITS-1:0] pitch_in, frac, ipart;
   logic [1:0] sel_in;
   logic tv_in;
   logic rsp_valid_ff;
   logic [PITCH_BITS-1:0] pitch_ff;
   logic [1:0] sel_ff;
   logic tv_ff;
   cell_type tail;
   logic signed [SH_BITS:0] sh;

   assign busy = 1'b0;

   always_comb begin
      head = '0;
      head.valid = start;
      head.tgt = req_target_rate;
      head.num = req_source_rate;
   end

   assign chain[0] = head;

   genvar g;
   generate
      for (g = 0; g < RATE_BITS; g++) begin : g_int
         srpr_cell u_cell (.clock(clock), .reset(reset), .idx(CNT_BITS'(g)),
                           .d_in(chain[g]), .d_out(chain[g+1]));
      end
   endgenerate

   srpr_norm u_norm (.clock(clock), .reset(reset), .d_in(chain[RATE_BITS]),
                     .d_out(chain[RATE_BITS+1]));

   generate
      for (g = RATE_BITS; g < NUM_CELLS; g++) begin : g_frac
         srpr_cell u_cell (.clock(clock), .reset(reset), .idx(CNT_BITS'(g)),
                           .d_in(chain[g+1]), .d_out(chain[g+2]));
      end
   endgenerate

   assign tail = chain[NUM_CELLS+1];

   always_comb begin
      ipart = PITCH_BITS'({{(PITCH_BITS-RATE_BITS){1'b0}}, tail.quo} << FRAC_BITS);
      sh = (SH_BITS+1)'(FRAC_BITS) - $signed({1'b0, tail.lz});
      if (sh >= 0) frac = tail.fq << sh;
      else frac = tail.fq >> (-sh);
      if (tail.tgt == '0) pitch_in = '0;
      else if (tail.fzero) pitch_in = ipart;
      else pitch_in = ipart | frac;
      sel_in = SEL_GENERAL;
      tv_in = 1'b1;
      if (pitch_in > WIN1_LO && pitch_in < WIN1_HI) sel_in = SEL_WIDE;
      else if (pitch_in == WIN2_A || pitch_in == WIN2_B) sel_in = SEL_1P84;
      else if (pitch_in == WIN3) sel_in = SEL_TWO;
      else if (pitch_in > WIN_MAX) tv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= tail.valid;
      pitch_ff <= pitch_in;
      sel_ff <= sel_in;
      tv_ff <= tv_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pitch = pitch_ff;
   assign rsp_table_select = sel_ff;
   assign rsp_table_valid = tv_ff;

   a_no_sel_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_table_valid |-> rsp_table_select == SEL_GENERAL)
      else $error("table select set with no table");
   a_zero_target: assert property (@(posedge clock) disable iff (reset)
      tail.valid && tail.tgt == '0 |=> rsp_pitch == '0)
      else $error("zero target gave nonzero pitch");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      tail.valid |=> rsp_valid)
      else $error("result lost at output stage");
endmodule

// File: bench/tb_sample_rate_pitch_ratio.sv
`timescale 1ns / 100ps

module tb_sample_rate_pitch_ratio;
   import srpr_pkg::*;

   typedef struct packed {
      logic [PITCH_BITS-1:0] pitch;
      logic [1:0]            table_select;
      logic                  table_valid;
   } pitch_result_type;

   // Computes the expected pitch and table choice and holds them in arrival order.
   class pitch_scoreboard_type;
      pitch_result_type pending_q[$];
      int            n_errors;

      function automatic logic [PITCH_BITS-1:0] ratio_pitch(logic [RATE_BITS-1:0] src,
                                                            logic [RATE_BITS-1:0] tgt);
         logic [63:0] ipart;
         logic [31:0] rem_scaled;
         logic [31:0] tgt_scaled;
         logic [63:0] norm;
         logic [31:0] frac;
         int          lead;
         int          shift;
         if (tgt == 0) return '0;
         ipart = 64'(src / tgt) << FRAC_BITS;
         rem_scaled = 32'(src % tgt) / 32'd100;
         tgt_scaled = 32'(tgt) / 32'd100;
         if (rem_scaled == 0 || tgt_scaled == 0) return ipart[31:0];
         lead = 31;
         while (lead > 0 && !rem_scaled[lead]) lead--;
         norm = 64'(rem_scaled) << (31 - lead);
         frac = norm[31:0] / tgt_scaled;
         shift = FRAC_BITS - (31 - lead);
         if (shift >= 0) begin
            norm = 64'(frac) << shift;
            frac = norm[31:0];
         end else begin
            frac = frac >> (-shift);
         end
         return ipart[31:0] | frac;
      endfunction

      function void note_item(logic [RATE_BITS-1:0] src, logic [RATE_BITS-1:0] tgt);
         pitch_result_type r;
         r.pitch = ratio_pitch(src, tgt);
         r.table_valid = 1'b1;
         if (r.pitch > WIN1_LO && r.pitch < WIN1_HI) r.table_select = SEL_WIDE;
         else if (r.pitch == WIN2_A || r.pitch == WIN2_B) r.table_select = SEL_1P84;
         else if (r.pitch == WIN3) r.table_select = SEL_TWO;
         else begin
            r.table_select = SEL_GENERAL;
            if (r.pitch > WIN_MAX) r.table_valid = 1'b0;
         end
         pending_q.push_back(r);
      endfunction

      function void check_result(pitch_result_type got);
         pitch_result_type exp_r;
         if (pending_q.size() == 0) begin
            $error("unexpected result: pitch %h", got.pitch);
            n_errors++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (got.pitch !== exp_r.pitch) begin
            $error("pitch: expected %h, got %h", exp_r.pitch, got.pitch);
            n_errors++;
         end
         if (got.table_select !== exp_r.table_select) begin
            $error("table_select: expected %0d, got %0d", exp_r.table_select,
                   got.table_select);
            n_errors++;
         end
         if (got.table_valid !== exp_r.table_valid) begin
            $error("table_valid: expected %0d, got %0d", exp_r.table_valid,
                   got.table_valid);
            n_errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [RATE_BITS-1:0]  req_source_rate = '0;
   logic [RATE_BITS-1:0]  req_target_rate = '0;
   logic                  rsp_valid;
   logic [PITCH_BITS-1:0] rsp_pitch;
   logic [1:0]            rsp_table_select;
   logic                  rsp_table_valid;

   pitch_scoreboard_type scoreboard = new();
   int              idle_pct = 0;
   int              quiet_cycles = 0;

   sample_rate_pitch_ratio u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_source_rate  (req_source_rate),
      .req_target_rate  (req_target_rate),
      .rsp_valid        (rsp_valid),
      .rsp_pitch        (rsp_pitch),
      .rsp_table_select (rsp_table_select),
      .rsp_table_valid  (rsp_table_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) scoreboard.note_item(req_source_rate, req_target_rate);
         if (rsp_valid) scoreboard.check_result({rsp_pitch, rsp_table_select, rsp_table_valid});
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Drives one item, with a random gap before it, and returns once it is taken.
   task automatic send_rates(logic [RATE_BITS-1:0] src, logic [RATE_BITS-1:0] tgt);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_source_rate <= src;
      req_target_rate <= tgt;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (scoreboard.pending_q.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_rates();
      logic [RATE_BITS-1:0] src;
      logic [RATE_BITS-1:0] tgt;
      int                   kind;
      kind = $urandom_range(9, 0);
      tgt = RATE_BITS'($urandom_range(262143, 100));
      case (kind)
         0: begin
            src = RATE_BITS'($urandom());
            tgt = RATE_BITS'($urandom());
         end
         1: src = RATE_BITS'(tgt * 2);
         2: begin
            tgt = RATE_BITS'($urandom_range(99, 0));
            src = RATE_BITS'($urandom());
         end
         3: begin
            tgt = RATE_BITS'($urandom_range(48000, 8000));
            src = RATE_BITS'(tgt * $urandom_range(8, 1) + $urandom_range(200, 0));
         end
         default: src = RATE_BITS'($urandom_range(262143, 0) >> $urandom_range(8, 0));
      endcase
      send_rates(src, tgt);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Extremes, every table window, small and zero targets, ratio equal to one.
      send_rates(18'd0, 18'd100);
      send_rates(18'h3ffff, 18'h3ffff);
      send_rates(18'h3ffff, 18'd100);
      send_rates(18'h3ffff, 18'd0);
      send_rates(18'd44100, 18'd0);
      send_rates(18'd44100, 18'd48000);
      send_rates(18'd48000, 18'd44100);
      send_rates(18'd96000, 18'd48000);
      send_rates(18'd88200, 18'd48000);
      send_rates(18'd8000, 18'd48000);
      send_rates(18'd12500, 18'd48000);
      send_rates(18'd121856, 18'd48000);
      send_rates(18'd192000, 18'd24000);
      send_rates(18'd192001, 18'd24000);
      send_rates(18'd5000, 18'd99);
      send_rates(18'd250, 18'd99);
      send_rates(18'd199, 18'd100);
      send_rates(18'd399, 18'd200);
      send_rates(18'd1, 18'd262143);
      send_rates(18'h2aaaa, 18'h15555);
      send_rates(18'h15555, 18'h2aaaa);
      send_rates(18'd262100, 18'd131100);
      drain_results();

      idle_pct = 23;
      repeat (450) send_random_rates();
      drain_results();
      idle_pct = 88;
      repeat (450) send_random_rates();
      idle_pct = 0;
      repeat (450) send_random_rates();
      drain_results();
      repeat (60) @(negedge clock);

      if (scoreboard.n_errors == 0 && scoreboard.pending_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
